FILE: src/mpc_pkg.sv
package mpc_pkg;

    // sizes
    localparam int MAX_WIDTH = 2048;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int LW_W      = 12;
    localparam int PIX_W     = 8;
    localparam int SAMPLE_W  = 9;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_MODE       = 1'b0,
        REG_LINE_WIDTH = 1'b1
    } cfg_reg_t;

    // codec direction
    typedef enum logic [0:0] {
        MODE_ENCODE = 1'b0,
        MODE_DECODE = 1'b1
    } mode_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       plane_start;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       row_end;
    } out_item_t;

    // position of one sample within its plane
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             top;
        logic             last;
    } pos_t;

endpackage

FILE: src/mpc_line_mem.sv
module mpc_line_mem (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [mpc_pkg::COL_W-1:0]   rd_addr,
    output logic [mpc_pkg::PIX_W-1:0]   rd_data,
    input  logic                        wr_en,
    input  logic [mpc_pkg::COL_W-1:0]   wr_addr,
    input  logic [mpc_pkg::PIX_W-1:0]   wr_data
);
    import mpc_pkg::*;

    logic [PIX_W-1:0] mem [MAX_WIDTH];
    logic [PIX_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/mpc_position.sv
module mpc_position (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       plane_start,
    input  logic [mpc_pkg::LW_W-1:0]   line_width,
    output mpc_pkg::pos_t              pos
);
    import mpc_pkg::*;

    logic [COL_W-1:0] column_pos_reg;
    logic [COL_W-1:0] column_pos_next;
    logic             on_top_row_reg;
    logic             on_top_row_next;
    logic [LW_W-1:0]  width_eff;
    logic [COL_W-1:0] col_cur;
    logic             top_cur;
    logic [LW_W-1:0]  col_plus_one;
    logic             last_cur;

    // clamp row width into 1..MAX_WIDTH
    always_comb
    begin
        if (line_width == '0)
        begin
            width_eff = LW_W'(1);
        end
        else if (line_width > LW_W'(MAX_WIDTH))
        begin
            width_eff = LW_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = line_width;
        end
    end

    // position of the offered sample, plane start restarts at top-left
    always_comb
    begin
        col_cur      = plane_start ? '0 : column_pos_reg;
        top_cur      = plane_start ? 1'b1 : on_top_row_reg;
        col_plus_one = LW_W'(col_cur) + LW_W'(1);
        last_cur     = (col_plus_one >= width_eff);
    end

    assign pos = '{col: col_cur, top: top_cur, last: last_cur};

    // next position
    always_comb
    begin
        column_pos_next = column_pos_reg;
        on_top_row_next = on_top_row_reg;
        if (advance)
        begin
            if (last_cur)
            begin
                column_pos_next = '0;
                on_top_row_next = 1'b0;
            end
            else
            begin
                column_pos_next = col_plus_one[COL_W-1:0];
                on_top_row_next = top_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_pos_reg <= '0;
            on_top_row_reg <= 1'b1;
        end
        else
        begin
            column_pos_reg <= column_pos_next;
            on_top_row_reg <= on_top_row_next;
        end
    end

endmodule

FILE: src/mpc_med_unit.sv
module mpc_med_unit (
    input  mpc_pkg::mode_t                      mode,
    input  logic signed [mpc_pkg::SAMPLE_W-1:0] sample,
    input  logic [mpc_pkg::PIX_W-1:0]           a,
    input  logic [mpc_pkg::PIX_W-1:0]           b,
    input  logic [mpc_pkg::PIX_W-1:0]           c,
    output logic [mpc_pkg::PIX_W-1:0]           pixel,
    output logic signed [mpc_pkg::SAMPLE_W-1:0] value
);
    import mpc_pkg::*;

    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic [PIX_W:0]   grad;
    logic [PIX_W-1:0] pred;

    // median edge detector
    always_comb
    begin
        lo   = (a < b) ? a : b;
        hi   = (a < b) ? b : a;
        grad = {1'b0, a} + {1'b0, b} - {1'b0, c};
        if (c >= hi)
        begin
            pred = lo;
        end
        else if (c <= lo)
        begin
            pred = hi;
        end
        else
        begin
            pred = grad[PIX_W-1:0];
        end
    end

    // residual or reconstruction, 8-bit wrap on decode
    always_comb
    begin
        case (mode)
            MODE_DECODE:
            begin
                pixel = pred + sample[PIX_W-1:0];
                value = SAMPLE_W'({1'b0, pixel});
            end
            default:
            begin
                pixel = sample[PIX_W-1:0];
                value = SAMPLE_W'({1'b0, pixel}) - SAMPLE_W'({1'b0, pred});
            end
        endcase
    end

endmodule

FILE: src/med_predictive_pixel_codec.sv
// Median edge detector predictive codec for one 8-bit image plane in raster order.
// Encode turns pixels into residuals, decode turns residuals back into pixels.
// The block sustains one sample transfer per clock while result_stall is low; each
// result passes through stage one, where the synchronous read of the previous row
// from the 2048-entry line memory completes, and then the output register. The
// row_end flag marks the last sample of each row of line_width samples, and
// plane_start on a sample restarts it at the top-left corner of a new plane.
// Write mode (offset 0) and line_width (offset 4) only while no sample is in flight.
module med_predictive_pixel_codec (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  mpc_pkg::in_item_t            sample_data,
    output logic                         result_valid,
    input  logic                         result_stall,
    output mpc_pkg::out_item_t           result_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mpc_pkg::ADDR_W-1:0]   paddr,
    input  logic [mpc_pkg::DATA_W-1:0]   pwdata,
    output logic [mpc_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import mpc_pkg::*;

    mode_t                 mode_reg;
    logic [LW_W-1:0]       line_width_reg;
    cfg_reg_t              cfg_sel;
    logic                  cfg_write;

    pos_t                  pos_cur;
    logic                  load;
    logic                  advance;

    logic                  s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_sample_reg;
    pos_t                  s1_pos_reg;

    logic                  fwd_reg;
    logic [PIX_W-1:0]      fwd_data_reg;
    logic [PIX_W-1:0]      mem_rd_data;

    logic [PIX_W-1:0]      left_pixel_reg;
    logic [PIX_W-1:0]      upper_left_reg;
    logic [PIX_W-1:0]      a_val;
    logic [PIX_W-1:0]      b_val;
    logic [PIX_W-1:0]      c_val;
    logic [PIX_W-1:0]      pixel;
    logic signed [SAMPLE_W-1:0] value;

    logic                  out_valid_reg;
    out_item_t             out_data_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_sel   = cfg_reg_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_ENCODE;
            line_width_reg <= LW_W'(MAX_WIDTH);
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_MODE:       mode_reg       <= mode_t'(pwdata[0]);
                REG_LINE_WIDTH: line_width_reg <= pwdata[LW_W-1:0];
                default:        mode_reg       <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_MODE:       prdata = DATA_W'(mode_reg);
            REG_LINE_WIDTH: prdata = DATA_W'(line_width_reg);
            default:        prdata = '0;
        endcase
    end

    // handshake: stage one moves on when the output register is free or draining
    assign advance      = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !advance;
    assign load         = sample_valid && !sample_stall;

    mpc_position u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (load),
        .plane_start (sample_data.plane_start),
        .line_width  (line_width_reg),
        .pos         (pos_cur)
    );

    // previous row lookup, written back when the sample leaves stage one
    mpc_line_mem u_line_mem (
        .clk     (clk),
        .rd_en   (load),
        .rd_addr (pos_cur.col),
        .rd_data (mem_rd_data),
        .wr_en   (advance),
        .wr_addr (s1_pos_reg.col),
        .wr_data (pixel)
    );

    // stage one control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // stage one payload and write-to-read forwarding on the same column
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_sample_reg <= sample_data.sample;
            s1_pos_reg    <= pos_cur;
            fwd_reg       <= advance && (s1_pos_reg.col == pos_cur.col);
            fwd_data_reg  <= pixel;
        end
    end

    // neighbors: left and upper-left zero in the left column, upper and upper-left zero on the top row
    always_comb
    begin
        a_val = (s1_pos_reg.col == '0) ? '0 : left_pixel_reg;
        b_val = s1_pos_reg.top ? '0 : (fwd_reg ? fwd_data_reg : mem_rd_data);
        c_val = (s1_pos_reg.top || (s1_pos_reg.col == '0)) ? '0 : upper_left_reg;
    end

    mpc_med_unit u_med (
        .mode   (mode_reg),
        .sample (s1_sample_reg),
        .a      (a_val),
        .b      (b_val),
        .c      (c_val),
        .pixel  (pixel),
        .value  (value)
    );

    // neighbor registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_pixel_reg <= '0;
            upper_left_reg <= '0;
        end
        else if (advance)
        begin
            left_pixel_reg <= pixel;
            upper_left_reg <= b_val;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= '{value: value, row_end: s1_pos_reg.last};
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

endmodule
